/* rtl/vec3_arith_normalize_unit_assert.svh */
// Assertion helpers for the vector unit.
// Each macro is a clocked concurrent check that is held off while reset is active.
`ifndef VEC3_ARITH_NORMALIZE_UNIT_ASSERT_SVH
`define VEC3_ARITH_NORMALIZE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define V3AN_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("vector unit assertion failed");
`define V3AN_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("vector unit forbidden condition seen");
`else
`define V3AN_ASSERT(lbl, clk, rst_n, prop)
`define V3AN_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/v3an_pkg.sv */
`timescale 1ns / 1ps

package v3an_pkg;

	localparam int NSQRT = 32;
	localparam int NDIV  = 48;
	localparam int NSTG  = 2 + NSQRT + NDIV + 1;

	typedef enum logic [3:0] {
		MODE_ADD   = 4'd0,
		MODE_SUB   = 4'd1,
		MODE_SCALE = 4'd2,
		MODE_DIV   = 4'd3,
		MODE_DOT   = 4'd4,
		MODE_CROSS = 4'd5,
		MODE_MAG   = 4'd6,
		MODE_DIST  = 4'd7,
		MODE_NORM  = 4'd8
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	localparam logic signed [65:0] Q_MAX66  = 66'sd2147483647;
	localparam logic signed [65:0] Q_MIN66  = -66'sd2147483648;
	localparam logic signed [65:0] RND_HALF = 66'sd32768;
	localparam logic [31:0]        Q_MAX32  = 32'h7FFF_FFFF;
	localparam logic [31:0]        Q_MIN32  = 32'h8000_0000;
	localparam logic signed [31:0] UNIT_Q   = 32'sd65536;

	typedef struct packed {
		logic signed [63:0] p;
		logic [63:0]        sq;
	} lane_prod_t;

	typedef struct packed {
		logic [31:0] v;
		logic        f;
	} sat_t;

	// clamp a wide signed value into Q16.16, flag when clamped
	function automatic sat_t sat_q(input logic signed [65:0] x);
		sat_t r;
		if (x > Q_MAX66) begin
			r.v = Q_MAX32;
			r.f = 1'b1;
		end else if (x < Q_MIN66) begin
			r.v = Q_MIN32;
			r.f = 1'b1;
		end else begin
			r.v = x[31:0];
			r.f = 1'b0;
		end
		return r;
	endfunction

endpackage

/* rtl/v3an_if.sv */
`timescale 1ns / 1ps

interface v3an_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         mode;
	logic signed [31:0] a_x;
	logic signed [31:0] a_y;
	logic signed [31:0] a_z;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] scale_value;

	modport source (output valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scale_value,
		input ready);
	modport sink (input valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scale_value,
		output ready);
endinterface

interface v3an_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_x;
	logic signed [31:0] res_y;
	logic signed [31:0] res_z;
	logic signed [31:0] res_scalar;
	logic [1:0]         status;

	modport source (output valid, res_x, res_y, res_z, res_scalar, status, input ready);
	modport sink (input valid, res_x, res_y, res_z, res_scalar, status, output ready);
endinterface

/* rtl/v3an_lane.sv */
`timescale 1ns / 1ps

// One vector component: products, square, add/sub, then round and clamp.
module v3an_lane (
	input  logic                 clk,
	input  logic                 en,
	input  v3an_pkg::mode_t      mode,
	input  logic signed [31:0]   a_i,
	input  logic signed [31:0]   b_i,
	input  logic signed [31:0]   a_j,
	input  logic signed [31:0]   b_j,
	input  logic signed [31:0]   a_k,
	input  logic signed [31:0]   b_k,
	input  logic signed [31:0]   s,
	output v3an_pkg::lane_prod_t prod_s1,
	output v3an_pkg::sat_t       res_s2
);

	logic signed [31:0] op_x;
	logic signed [31:0] op_y;
	logic signed [63:0] p_nx;
	logic signed [63:0] q_nx;
	logic signed [32:0] as_nx;
	logic signed [32:0] diff;
	logic signed [32:0] src;
	logic [32:0]        mag;
	logic [63:0]        sq_nx;
	v3an_pkg::mode_t    mode_s1;
	logic signed [63:0] q_s1;
	logic signed [32:0] as_s1;
	logic signed [65:0] t66;
	logic signed [65:0] rnd;
	v3an_pkg::sat_t     res_nx;

	always_comb begin
		op_x = (mode == v3an_pkg::MODE_CROSS) ? a_j : a_i;
		case (mode)
			v3an_pkg::MODE_SCALE: op_y = s;
			v3an_pkg::MODE_CROSS: op_y = b_k;
			default:              op_y = b_i;
		endcase
	end

	assign p_nx  = op_x * op_y;
	assign q_nx  = a_k * b_j;
	assign as_nx = (mode == v3an_pkg::MODE_SUB) ? ({a_i[31], a_i} - {b_i[31], b_i})
		: ({a_i[31], a_i} + {b_i[31], b_i});
	assign diff  = {b_i[31], b_i} - {a_i[31], a_i};
	assign src   = (mode == v3an_pkg::MODE_DIST) ? diff : {a_i[31], a_i};
	assign mag   = src[32] ? -src : src;
	assign sq_nx = {32'b0, mag[31:0]} * {32'b0, mag[31:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.p  <= p_nx;
			prod_s1.sq <= sq_nx;
			q_s1       <= q_nx;
			as_s1      <= as_nx;
			mode_s1    <= mode;
		end
	end

	// round half up at bit 15, then clamp
	always_comb begin
		t66 = {{2{prod_s1.p[63]}}, prod_s1.p} + v3an_pkg::RND_HALF;
		if (mode_s1 == v3an_pkg::MODE_CROSS) begin
			t66 = t66 - {{2{q_s1[63]}}, q_s1};
		end
		case (mode_s1)
			v3an_pkg::MODE_ADD, v3an_pkg::MODE_SUB: rnd = {{33{as_s1[32]}}, as_s1};
			v3an_pkg::MODE_SCALE, v3an_pkg::MODE_CROSS: rnd = t66 >>> 16;
			default: rnd = '0;
		endcase
	end

	assign res_nx = v3an_pkg::sat_q(rnd);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res_nx;
		end
	end

endmodule

/* rtl/v3an_sqrt.sv */
`timescale 1ns / 1ps

// Pipelined bit-pair square root, one result bit per stage.
module v3an_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	logic [63:0] rem_s [v3an_pkg::NSQRT-1];
	logic [63:0] acc_s [v3an_pkg::NSQRT];

	genvar k;
	generate
		for (k = 0; k < v3an_pkg::NSQRT; k++) begin : g_stg
			localparam logic [63:0] ONE = 64'd1 << (62 - 2 * k);
			logic [63:0] x_in;
			logic [63:0] r_in;
			logic [63:0] trial;
			logic        ge;

			if (k == 0) begin : g_first
				assign x_in = rad;
				assign r_in = '0;
			end else begin : g_next
				assign x_in = rem_s[k-1];
				assign r_in = acc_s[k-1];
			end

			assign trial = r_in + ONE;
			assign ge    = x_in >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[k] <= ge ? ((r_in >> 1) + ONE) : (r_in >> 1);
				end
			end

			if (k < v3an_pkg::NSQRT - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[k] <= ge ? (x_in - trial) : x_in;
					end
				end
			end
		end
	endgenerate

	assign root = acc_s[v3an_pkg::NSQRT-1][31:0];

endmodule

/* rtl/v3an_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
module v3an_div (
	input  logic        clk,
	input  logic        en,
	input  logic [47:0] dvd,
	input  logic [31:0] dsr,
	output logic [47:0] quo
);

	logic [47:0] w_s   [v3an_pkg::NDIV];
	logic [31:0] rem_s [v3an_pkg::NDIV-1];
	logic [31:0] d_s   [v3an_pkg::NDIV-1];

	genvar k;
	generate
		for (k = 0; k < v3an_pkg::NDIV; k++) begin : g_stg
			logic [47:0] w_in;
			logic [31:0] rem_in;
			logic [31:0] d_in;
			logic [32:0] tmp;
			logic [32:0] sub;
			logic        ge;

			if (k == 0) begin : g_first
				assign w_in   = dvd;
				assign rem_in = '0;
				assign d_in   = dsr;
			end else begin : g_next
				assign w_in   = w_s[k-1];
				assign rem_in = rem_s[k-1];
				assign d_in   = d_s[k-1];
			end

			assign tmp = {rem_in, w_in[47]};
			assign sub = tmp - {1'b0, d_in};
			assign ge  = tmp >= {1'b0, d_in};

			always_ff @(posedge clk) begin
				if (en) begin
					w_s[k] <= {w_in[46:0], ge};
				end
			end

			if (k < v3an_pkg::NDIV - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[k] <= ge ? sub[31:0] : tmp[31:0];
						d_s[k]   <= d_in;
					end
				end
			end
		end
	endgenerate

	assign quo = w_s[v3an_pkg::NDIV-1];

endmodule

/* rtl/vec3_arith_normalize_unit.sv */
// Throughput: one item per cycle unless the output stalls; every mode runs the same fixed-length pipeline
// (2 product/merge stages, 32 square root stages, 48 divider stages, output register).
// A stalled output holds the whole pipeline in place.
// Reset (arst_n low) clears the stage valid bits only; no result is offered after it.
`timescale 1ns / 1ps
`include "vec3_arith_normalize_unit_assert.svh"

module vec3_arith_normalize_unit (
	input logic        clk,
	input logic        arst_n,
	v3an_req_if.sink   req,
	v3an_rsp_if.source rsp
);

	// item state carried along the long stages
	typedef struct packed {
		v3an_pkg::mode_t mode;
		logic [2:0][31:0] a;
		logic             s_neg;
		logic             s_zero;
		logic [31:0]      s_mag;
		logic             big;
		logic [2:0][31:0] vec;
		logic [31:0]      scalar;
		logic             sat;
		logic [2:0]       qneg;
	} pay_t;

	localparam int LAST = v3an_pkg::NSTG - 1;

	// global advance: every stage moves when the output slot is free or being taken
	logic                    adv;
	logic [LAST:0]           vld_q;
	logic                    out_vld;

	logic signed [31:0]      a_v [3];
	logic signed [31:0]      b_v [3];
	v3an_pkg::mode_t         mode_in;
	v3an_pkg::lane_prod_t    prod_s1 [3];
	v3an_pkg::sat_t          lres_s2 [3];

	// stage 1 side registers
	v3an_pkg::mode_t         mode_s1;
	logic [2:0][31:0]        a_s1;
	logic [31:0]             s_s1;

	// merge
	logic signed [65:0]      dsum;
	logic signed [65:0]      dsh;
	v3an_pkg::sat_t          dot_r;
	logic [65:0]             sqsum;
	pay_t                    pay_nx;
	pay_t                    pay_s2;
	logic [63:0]             rad_s2;
	pay_t                    pay_in;

	// square root section
	pay_t                    sq_pl [v3an_pkg::NSQRT];
	logic [31:0]             root;
	pay_t                    pay_sq;
	logic [31:0]             amag [3];
	logic [47:0]             dvd [3];
	logic [31:0]             dsr;

	// divider section
	pay_t                    dv_pl [v3an_pkg::NDIV];
	logic [47:0]             quo [3];

	// final select
	pay_t                    pd;
	logic signed [65:0]      qv [3];
	v3an_pkg::sat_t          qs [3];
	logic [2:0][31:0]        vec_f;
	logic [31:0]             sc_f;
	logic                    sat_f;
	logic                    divz;
	v3an_pkg::status_t       status_f;

	// output register
	logic [31:0]             res_x_q;
	logic [31:0]             res_y_q;
	logic [31:0]             res_z_q;
	logic [31:0]             scalar_q;
	v3an_pkg::status_t       status_q;
	v3an_pkg::mode_t         mode_q;

	assign out_vld   = vld_q[LAST];
	assign adv       = !out_vld || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAST-1:0], req.valid};
		end
	end

	assign a_v[0]  = req.a_x;
	assign a_v[1]  = req.a_y;
	assign a_v[2]  = req.a_z;
	assign b_v[0]  = req.b_x;
	assign b_v[1]  = req.b_y;
	assign b_v[2]  = req.b_z;
	assign mode_in = v3an_pkg::mode_t'(req.mode);

	// three component lanes; lane i sees the other two components rotated for cross
	genvar i;
	generate
		for (i = 0; i < 3; i++) begin : g_lane
			localparam int J = (i + 1) % 3;
			localparam int K = (i + 2) % 3;

			v3an_lane u_lane (
				.clk     (clk),
				.en      (adv),
				.mode    (mode_in),
				.a_i     (a_v[i]),
				.b_i     (b_v[i]),
				.a_j     (a_v[J]),
				.b_j     (b_v[J]),
				.a_k     (a_v[K]),
				.b_k     (b_v[K]),
				.s       (req.scale_value),
				.prod_s1 (prod_s1[i]),
				.res_s2  (lres_s2[i])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode_in;
			a_s1    <= {req.a_z, req.a_y, req.a_x};
			s_s1    <= req.scale_value;
		end
	end

	// merge: dot product sum and squared length sum across lanes
	assign dsum = {{2{prod_s1[0].p[63]}}, prod_s1[0].p}
		+ {{2{prod_s1[1].p[63]}}, prod_s1[1].p}
		+ {{2{prod_s1[2].p[63]}}, prod_s1[2].p}
		+ v3an_pkg::RND_HALF;
	assign dsh   = dsum >>> 16;
	assign dot_r = v3an_pkg::sat_q(dsh);
	assign sqsum = {2'b0, prod_s1[0].sq} + {2'b0, prod_s1[1].sq} + {2'b0, prod_s1[2].sq};

	always_comb begin
		pay_nx        = '0;
		pay_nx.mode   = mode_s1;
		pay_nx.a      = a_s1;
		pay_nx.s_neg  = s_s1[31];
		pay_nx.s_zero = (s_s1 == '0);
		pay_nx.s_mag  = s_s1[31] ? -s_s1 : s_s1;
		pay_nx.big    = |sqsum[65:64];
		if (mode_s1 == v3an_pkg::MODE_DOT) begin
			pay_nx.scalar = dot_r.v;
			pay_nx.sat    = dot_r.f;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s2 <= pay_nx;
			rad_s2 <= sqsum[63:0];
		end
	end

	// lane results land in the same stage as the merge results
	always_comb begin
		pay_in = pay_s2;
		for (int n = 0; n < 3; n++) begin
			pay_in.vec[n] = lres_s2[n].v;
		end
		pay_in.sat = pay_s2.sat | lres_s2[0].f | lres_s2[1].f | lres_s2[2].f;
	end

	v3an_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s2),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_pl[0] <= pay_in;
			for (int n = 1; n < v3an_pkg::NSQRT; n++) begin
				sq_pl[n] <= sq_pl[n-1];
			end
		end
	end

	// length result, divider operands; normalize divides by the floor length
	always_comb begin
		pay_sq = sq_pl[v3an_pkg::NSQRT-1];
		if (pay_sq.mode == v3an_pkg::MODE_MAG || pay_sq.mode == v3an_pkg::MODE_DIST) begin
			if (pay_sq.big || root[31]) begin
				pay_sq.scalar = v3an_pkg::Q_MAX32;
				pay_sq.sat    = 1'b1;
			end else begin
				pay_sq.scalar = root;
			end
		end
		for (int n = 0; n < 3; n++) begin
			amag[n]        = pay_sq.a[n][31] ? -pay_sq.a[n] : pay_sq.a[n];
			dvd[n]         = {amag[n], 16'b0};
			pay_sq.qneg[n] = pay_sq.a[n][31]
				^ (pay_sq.mode == v3an_pkg::MODE_DIV && pay_sq.s_neg);
		end
		dsr = (pay_sq.mode == v3an_pkg::MODE_DIV) ? pay_sq.s_mag : root;
	end

	generate
		for (i = 0; i < 3; i++) begin : g_div
			v3an_div u_div (
				.clk (clk),
				.en  (adv),
				.dvd (dvd[i]),
				.dsr (dsr),
				.quo (quo[i])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_pl[0] <= pay_sq;
			for (int n = 1; n < v3an_pkg::NDIV; n++) begin
				dv_pl[n] <= dv_pl[n-1];
			end
		end
	end

	// final select: quotient-based modes replace the vector, status from flags
	always_comb begin
		pd = dv_pl[v3an_pkg::NDIV-1];
		for (int n = 0; n < 3; n++) begin
			qv[n] = pd.qneg[n] ? -{18'b0, quo[n]} : {18'b0, quo[n]};
			qs[n] = v3an_pkg::sat_q(qv[n]);
		end
		vec_f = pd.vec;
		sc_f  = pd.scalar;
		sat_f = pd.sat;
		divz  = 1'b0;
		case (pd.mode)
			v3an_pkg::MODE_DIV: begin
				if (pd.s_zero) begin
					vec_f = '0;
					divz  = 1'b1;
				end else begin
					for (int n = 0; n < 3; n++) begin
						vec_f[n] = qs[n].v;
					end
					sat_f = qs[0].f | qs[1].f | qs[2].f;
				end
			end
			v3an_pkg::MODE_NORM: begin
				// all-zero vector stays zero
				if (pd.a != '0) begin
					for (int n = 0; n < 3; n++) begin
						vec_f[n] = qs[n].v;
					end
					sat_f = qs[0].f | qs[1].f | qs[2].f;
				end
			end
			default: ;
		endcase
		if (divz) begin
			status_f = v3an_pkg::ST_DIVZ;
		end else if (sat_f) begin
			status_f = v3an_pkg::ST_SAT;
		end else begin
			status_f = v3an_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_x_q  <= vec_f[0];
			res_y_q  <= vec_f[1];
			res_z_q  <= vec_f[2];
			scalar_q <= sc_f;
			status_q <= status_f;
			mode_q   <= pd.mode;
		end
	end

	assign rsp.valid      = out_vld;
	assign rsp.res_x      = res_x_q;
	assign rsp.res_y      = res_y_q;
	assign rsp.res_z      = res_z_q;
	assign rsp.res_scalar = scalar_q;
	assign rsp.status     = status_q;

	function automatic logic in_unit(input logic [31:0] v);
		return ($signed(v) <= v3an_pkg::UNIT_Q) && ($signed(v) >= -v3an_pkg::UNIT_Q);
	endfunction

	function automatic logic is_scalar_mode(input v3an_pkg::mode_t m);
		return m == v3an_pkg::MODE_DOT || m == v3an_pkg::MODE_MAG || m == v3an_pkg::MODE_DIST;
	endfunction

	// divide-by-zero only ever comes out of divide mode
	`V3AN_ASSERT(a_divz_mode, clk, arst_n, out_vld && status_q == v3an_pkg::ST_DIVZ |-> mode_q == v3an_pkg::MODE_DIV)
	// scalar modes leave the vector outputs at zero
	`V3AN_ASSERT_NEVER(a_scalar_vec, clk, arst_n, out_vld && is_scalar_mode(mode_q) && (res_x_q | res_y_q | res_z_q) != '0)
	// a normalized component never exceeds one in magnitude
	`V3AN_ASSERT(a_norm_unit, clk, arst_n, out_vld && mode_q == v3an_pkg::MODE_NORM |-> in_unit(res_x_q) && in_unit(res_y_q) && in_unit(res_z_q))

endmodule

/* verif/tb_vec3_arith_normalize_unit.sv */
`timescale 1ns / 1ps

// Testbench for the Q16.16 three-component vector unit.
// Items go in on the request channel, results come back on the response channel
// in order; each result is checked against an in-order predictor.

module tb_vec3_arith_normalize_unit;

	typedef struct {
		logic [3:0]         mode;
		logic signed [31:0] a [3];
		logic signed [31:0] b [3];
		logic signed [31:0] s;
	} vec_op_t;

	typedef struct {
		logic signed [31:0] r [3];
		logic signed [31:0] sc;
		logic [1:0]         st;
	} vec_res_t;

	logic clk = 1'b0;
	logic arst_n;

	v3an_req_if req_ch();
	v3an_rsp_if rsp_ch();

	vec3_arith_normalize_unit u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	vec_res_t pending_results[$];
	int       err_count = 0;
	bit       no_gaps   = 1'b0;   // set during the back-to-back stretch

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// Clamp to Q16.16; flag is set when clamping happens.
	function automatic logic [31:0] clamp_q(input logic signed [65:0] v, inout bit flag);
		if (v > 66'sd2147483647) begin
			flag = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -66'sd2147483648) begin
			flag = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// Round half up from Q32.32 down to Q16.16 (floor of value plus half LSB).
	function automatic logic signed [65:0] round_q(input logic signed [65:0] v);
		return (v + 66'sd32768) >>> 16;
	endfunction

	// Bit-serial floor square root, 32 steps.
	function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] one;
		res = '0;
		one = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= res + one) begin
				x   = x - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	// Floor length from three signed components; big set when squares reach 2^64.
	function automatic logic [63:0] vec_length(input logic signed [65:0] c [3], output bit big);
		logic [67:0] sum;
		logic [65:0] m;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			m   = (c[i] < 0) ? -c[i] : c[i];
			sum = sum + 68'(m) * 68'(m);
		end
		big = (sum[67:64] != 0);
		return big ? 64'd0 : sqrt_floor(sum[63:0]);
	endfunction

	function automatic vec_res_t predict_vec(input vec_op_t op);
		vec_res_t          e;
		bit                flag;
		bit                big;
		logic signed [65:0] wa [3];
		logic signed [65:0] wb [3];
		logic signed [65:0] c [3];
		logic signed [65:0] ws;
		logic signed [65:0] acc;
		logic [63:0]        len;
		int                 j;
		int                 k;
		flag = 1'b0;
		e.r[0] = '0; e.r[1] = '0; e.r[2] = '0;
		e.sc = '0;
		e.st = v3an_pkg::ST_OK;
		for (int i = 0; i < 3; i++) begin
			wa[i] = op.a[i];
			wb[i] = op.b[i];
		end
		ws = op.s;
		case (op.mode)
			v3an_pkg::MODE_ADD: begin
				for (int i = 0; i < 3; i++) e.r[i] = clamp_q(wa[i] + wb[i], flag);
			end
			v3an_pkg::MODE_SUB: begin
				for (int i = 0; i < 3; i++) e.r[i] = clamp_q(wa[i] - wb[i], flag);
			end
			v3an_pkg::MODE_SCALE: begin
				for (int i = 0; i < 3; i++) e.r[i] = clamp_q(round_q(wa[i] * ws), flag);
			end
			v3an_pkg::MODE_DIV: begin
				if (ws == 0)
					e.st = v3an_pkg::ST_DIVZ;
				else
					for (int i = 0; i < 3; i++) e.r[i] = clamp_q((wa[i] * 66'sd65536) / ws, flag);
			end
			v3an_pkg::MODE_DOT: begin
				acc = wa[0] * wb[0] + wa[1] * wb[1] + wa[2] * wb[2];
				e.sc = clamp_q(round_q(acc), flag);
			end
			v3an_pkg::MODE_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					j = (i + 1) % 3;
					k = (i + 2) % 3;
					e.r[i] = clamp_q(round_q(wa[j] * wb[k] - wa[k] * wb[j]), flag);
				end
			end
			v3an_pkg::MODE_MAG, v3an_pkg::MODE_DIST: begin
				for (int i = 0; i < 3; i++)
					c[i] = (op.mode == v3an_pkg::MODE_MAG) ? wa[i] : wb[i] - wa[i];
				len = vec_length(c, big);
				if (big || len > 64'd2147483647) begin
					len  = 64'd2147483647;
					flag = 1'b1;
				end
				e.sc = len[31:0];
			end
			v3an_pkg::MODE_NORM: begin
				if (wa[0] != 0 || wa[1] != 0 || wa[2] != 0) begin
					len = vec_length(wa, big);
					if (len == 0) len = 64'd1;
					for (int i = 0; i < 3; i++)
						e.r[i] = clamp_q((wa[i] * 66'sd65536) / $signed({2'b00, len}), flag);
				end
			end
			default: ;   // unused modes give all zero, ok
		endcase
		if (e.st == v3an_pkg::ST_OK && flag) e.st = v3an_pkg::ST_SAT;
		return e;
	endfunction

	// ---------------------------------------------------------------
	// Driver: one item per call, random idle cycles before it
	// ---------------------------------------------------------------

	task automatic send_vec(input vec_op_t op);
		while (!no_gaps && $urandom_range(99) < 32) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.mode        <= op.mode;
		req_ch.a_x         <= op.a[0];
		req_ch.a_y         <= op.a[1];
		req_ch.a_z         <= op.a[2];
		req_ch.b_x         <= op.b[0];
		req_ch.b_y         <= op.b[1];
		req_ch.b_z         <= op.b[2];
		req_ch.scale_value <= op.s;
		do @(posedge clk); while (!req_ch.ready);
		// transfer happened at this edge
		pending_results.push_back(predict_vec(op));
	endtask

	function automatic vec_op_t make_vec(input logic [3:0] m,
		input logic signed [31:0] ax, ay, az, bx, by, bz, s);
		vec_op_t op;
		op.mode = m;
		op.a[0] = ax; op.a[1] = ay; op.a[2] = az;
		op.b[0] = bx; op.b[1] = by; op.b[2] = bz;
		op.s = s;
		return op;
	endfunction

	// Mix of full-range, extreme, small and mid-size Q16.16 values.
	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(4))
			0: return $urandom;
			1: case ($urandom_range(4))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'd0;
				3: return 32'd1;
				default: return 32'hFFFF_FFFF;
			endcase
			2: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
			3: return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
			default: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
		endcase
	endfunction

	function automatic vec_op_t rand_vec();
		logic [3:0] m;
		m = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
		return make_vec(m, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
			rand_q());
	endfunction

	// ---------------------------------------------------------------
	// Monitor / checker, also drives response backpressure
	// ---------------------------------------------------------------

	task automatic cmp_field(input string name, input logic [31:0] exp_v, act_v);
		if (exp_v !== act_v) begin
			err_count++;
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		vec_res_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result: expected none, got %h %h %h %h st %0d",
					$realtime, rsp_ch.res_x, rsp_ch.res_y, rsp_ch.res_z,
					rsp_ch.res_scalar, rsp_ch.status);
			end else begin
				e = pending_results.pop_front();
				cmp_field("res_x", e.r[0], rsp_ch.res_x);
				cmp_field("res_y", e.r[1], rsp_ch.res_y);
				cmp_field("res_z", e.r[2], rsp_ch.res_z);
				cmp_field("res_scalar", e.sc, rsp_ch.res_scalar);
				cmp_field("status", 32'(e.st), 32'(rsp_ch.status));
			end
		end
		rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 32);
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	localparam logic signed [31:0] QMX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] QMN = 32'sh8000_0000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	// Field extremes across every mode.
	task automatic test_extremes();
		for (int m = v3an_pkg::MODE_ADD; m <= v3an_pkg::MODE_NORM; m++) begin
			send_vec(make_vec(4'(m), QMX, QMN, QMX, QMX, QMX, QMN, QMX));
			send_vec(make_vec(4'(m), QMN, QMN, QMN, QMX, QMN, QMX, QMN));
		end
	endtask

	// Divide by zero, normalize of the zero vector, unused modes, exact unit cases.
	task automatic test_special_cases();
		send_vec(make_vec(v3an_pkg::MODE_DIV, ONE, -ONE, QMX, 0, 0, 0, 0));
		send_vec(make_vec(v3an_pkg::MODE_NORM, 0, 0, 0, ONE, ONE, ONE, ONE));
		send_vec(make_vec(v3an_pkg::MODE_NORM, 1, 0, 0, 0, 0, 0, 0));
		send_vec(make_vec(v3an_pkg::MODE_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0));
		send_vec(make_vec(4'd9, QMX, QMX, QMX, QMX, QMX, QMX, QMX));
		send_vec(make_vec(4'd15, -1, -1, -1, -1, -1, -1, -1));
	endtask

	task automatic test_random_mix(input int n);
		repeat (n) send_vec(rand_vec());
	endtask

	// No idle cycles on either side: full-rate streaming.
	task automatic test_back_to_back(input int n);
		no_gaps = 1'b1;
		repeat (n) send_vec(rand_vec());
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.mode         <= '0;
		req_ch.a_x          <= '0;
		req_ch.a_y          <= '0;
		req_ch.a_z          <= '0;
		req_ch.b_x          <= '0;
		req_ch.b_y          <= '0;
		req_ch.b_z          <= '0;
		req_ch.scale_value  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_special_cases();
		test_random_mix(700);
		test_back_to_back(300);
		test_random_mix(500);

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);   // catch any stray result past the pipeline depth
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog: ~1600 items through an 83-stage pipe with stalls needs far less.
	initial begin
		#1000000;
		$display("FAIL");
		$finish;
	end

endmodule
